/* design/gyro_angle_integrator_core_assert.svh */
// Assertion helpers for the gyro angle integrator.
`ifndef GYRO_ANGLE_INTEGRATOR_CORE_ASSERT_SVH
`define GYRO_ANGLE_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GAI_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gai assertion failed");

// Next-cycle implication, checked outside reset.
`define GAI_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gai assertion failed");

`endif

/* design/gai_pkg.sv */
`default_nettype none

package gai_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_RATE_GAIN     = 2'd1,
    REG_CAL_COUNT     = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd2000;
  localparam logic [23:0] RATE_GAIN_RESET     = 24'd2462907;
  localparam logic [15:0] CAL_COUNT_RESET     = 16'd1000;

  localparam logic [19:0] ELAPSED_RESET = 20'd10000;
  localparam logic [19:0] ELAPSED_MAX   = 20'd1000000;

  // Angles in units of 2^-32 degree
  localparam logic signed [46:0] HALF_TURN  = 47'sd773094113280;
  localparam logic signed [46:0] FULL_TURN  = 47'sd1546188226560;
  localparam logic signed [40:0] ANGLE_HALF = 41'sd773094113280;

  // Command from the sequencer to each axis lane
  typedef struct packed {
    logic        integ;
    logic        cal;
    logic        cal_complete;
    logic [19:0] elapsed;
    logic [23:0] gain;
    logic [15:0] divisor;
  } lane_cmd_t;

endpackage

`default_nettype wire

/* design/gai_sample_if.sv */
`default_nettype none

interface gai_sample_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic        [15:0] delta_us;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;

  modport source (output valid, action, delta_us, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, action, delta_us, raw_x, raw_y, raw_z, output ready);
endinterface

`default_nettype wire

/* design/gai_result_if.sv */
`default_nettype none

interface gai_result_if;
  logic               valid;
  logic               ready;
  logic signed [40:0] angle_x;
  logic signed [40:0] angle_y;
  logic signed [40:0] angle_z;
  logic               angle_updated;
  logic               calibration_done;

  modport source (output valid, angle_x, angle_y, angle_z, angle_updated, calibration_done,
                  input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, angle_updated, calibration_done,
                output ready);
endinterface

`default_nettype wire

/* design/gai_cfg_if.sv */
`default_nettype none

interface gai_cfg_if
  import gai_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/gai_lane.sv */
`default_nettype none

module gai_lane
  import gai_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lane_cmd_t          cmd,
  input  logic signed [15:0] raw,
  output logic signed [40:0] angle,
  output logic               busy
);

  typedef enum logic [3:0] {
    L_IDLE,
    L_MUL_P,
    L_MUL_LO,
    L_MUL_HI,
    L_ADD,
    L_ACC,
    L_RED,
    L_DIV,
    L_SAT
  } lane_state_t;

  localparam int          DIV_STEPS = 48;
  localparam logic [47:0] POS_LIMIT = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h0000_8000_0000;

  lane_state_t        state;
  logic signed [31:0] bias;
  logic signed [31:0] sum;
  logic signed [32:0] diff;
  logic [19:0]        elap;
  logic [23:0]        gain;
  logic signed [52:0] prod_p;
  logic [50:0]        prod_lo;
  logic signed [49:0] prod_hi;
  logic signed [44:0] delta;
  logic signed [46:0] acc;
  logic [15:0]        rem;
  logic [15:0]        divisor;
  logic [47:0]        quo;
  logic [5:0]         div_cnt;
  logic               div_neg;

  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_prod;
  logic [76:0]        full_sum;
  logic signed [31:0] sum_next;
  logic [31:0]        sum_mag;
  logic [16:0]        trial;
  logic [16:0]        trial_sub;
  logic               trial_ge;
  logic signed [31:0] bias_sat;

  // Shared multiplier: diff * elapsed, then the two halves of p * gain
  always_comb begin
    case (state)
      L_MUL_LO: begin
        mul_a = {7'b0, prod_p[26:0]};
        mul_b = {1'b0, gain};
      end
      L_MUL_HI: begin
        mul_a = {{8{prod_p[52]}}, prod_p[52:27]};
        mul_b = {1'b0, gain};
      end
      default: begin
        mul_a = {diff[32], diff};
        mul_b = {5'b0, elap};
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;
  assign full_sum = {prod_hi, 27'b0} + {26'b0, prod_lo};

  assign sum_next = sum + {{16{raw[15]}}, raw};
  assign sum_mag  = sum_next[31] ? (32'd0 - sum_next) : sum_next;

  assign trial     = {rem, quo[47]};
  assign trial_ge  = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    if (div_neg) begin
      bias_sat = (quo > NEG_LIMIT) ? 32'sh8000_0000 : 32'd0 - quo[31:0];
    end else begin
      bias_sat = (quo > POS_LIMIT) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      angle <= '0;
      bias  <= '0;
      sum   <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (cmd.integ) begin
            diff  <= {{1{raw[15]}}, raw, 16'b0} - {bias[31], bias};
            elap  <= cmd.elapsed;
            gain  <= cmd.gain;
            state <= L_MUL_P;
          end else if (cmd.cal) begin
            if (cmd.cal_complete) begin
              sum     <= '0;
              div_neg <= sum_next[31];
              quo     <= {sum_mag, 16'b0};
              rem     <= '0;
              divisor <= cmd.divisor;
              div_cnt <= 6'(DIV_STEPS - 1);
              state   <= L_DIV;
            end else begin
              sum <= sum_next;
            end
          end
        end
        L_MUL_P: begin
          prod_p <= mul_prod[52:0];
          state  <= L_MUL_LO;
        end
        L_MUL_LO: begin
          prod_lo <= mul_prod[50:0];
          state   <= L_MUL_HI;
        end
        L_MUL_HI: begin
          prod_hi <= mul_prod[49:0];
          state   <= L_ADD;
        end
        L_ADD: begin
          // floor of the product over 2^32
          delta <= full_sum[76:32];
          state <= L_ACC;
        end
        L_ACC: begin
          acc   <= {{6{angle[40]}}, angle} + {{2{delta[44]}}, delta};
          state <= L_RED;
        end
        L_RED: begin
          // Drop one full turn per cycle until within half a turn
          if (acc > HALF_TURN) begin
            acc <= acc - FULL_TURN;
          end else if (acc < -HALF_TURN) begin
            acc <= acc + FULL_TURN;
          end else begin
            angle <= acc[40:0];
            state <= L_IDLE;
          end
        end
        L_DIV: begin
          rem <= trial_ge ? trial_sub[15:0] : trial[15:0];
          quo <= {quo[46:0], trial_ge};
          if (div_cnt == '0) begin
            state <= L_SAT;
          end else begin
            div_cnt <= div_cnt - 6'd1;
          end
        end
        L_SAT: begin
          bias  <= bias_sat;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign busy = (state != L_IDLE);

endmodule

`default_nettype wire

/* design/gyro_angle_integrator_core.sv */
// Sequence: a tick without an integration step, or a calibration sample that does not complete,
// is loaded from the sequencer's run state into the output register once that register is free;
// an integration step runs each lane through L_MUL_P to L_RED, repeating L_RED once per full turn
// removed from an angle; a completed calibration runs the 48-step bit-serial bias divider per axis lane.
// Throughput: one item at a time; the next transfer is taken the cycle after the result loads.
// Reset (rst, synchronous): registers to defaults, elapsed time 10000 us, angles, biases
// and calibration sums to zero; the output register empties.
`default_nettype none

`include "gyro_angle_integrator_core_assert.svh"

module gyro_angle_integrator_core
  import gai_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  gai_sample_if.sink   sample,
  gai_result_if.source result,
  gai_cfg_if.sink      cfg
);

  typedef enum logic {S_IDLE, S_RUN} core_state_t;

  core_state_t        state;
  logic               res_valid;
  logic signed [40:0] res_angle_x;
  logic signed [40:0] res_angle_y;
  logic signed [40:0] res_angle_z;
  logic               res_updated;
  logic               res_done;
  logic               pend_updated;
  logic               pend_done;

  logic [19:0] elapsed;
  logic [15:0] seen;
  logic [15:0] sample_period;
  logic [23:0] rate_gain;
  logic [15:0] cal_count;

  logic               accept;
  logic [20:0]        elapsed_sum;
  logic [19:0]        elapsed_sat;
  logic               integ_now;
  logic [15:0]        seen_inc;
  logic [15:0]        cal_div;
  logic               cal_complete;
  lane_cmd_t          cmd;
  logic signed [40:0] lane_angle_x;
  logic signed [40:0] lane_angle_y;
  logic signed [40:0] lane_angle_z;
  logic [2:0]         lane_busy;
  logic               lanes_busy;
  logic               res_load;
  logic               res_in_range;

  assign accept = sample.valid && sample.ready;

  assign elapsed_sum = {1'b0, elapsed} + {5'b0, sample.delta_us};
  assign elapsed_sat = (elapsed_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : elapsed_sum[19:0];
  assign integ_now   = elapsed_sat >= {4'b0, sample_period};

  assign seen_inc     = seen + 16'd1;
  assign cal_div      = (cal_count == '0) ? 16'd1 : cal_count;
  assign cal_complete = seen_inc >= cal_div;

  always_comb begin
    cmd.integ        = accept && !sample.action && integ_now;
    cmd.cal          = accept && sample.action;
    cmd.cal_complete = cal_complete;
    cmd.elapsed      = elapsed_sat;
    cmd.gain         = rate_gain;
    cmd.divisor      = cal_div;
  end

  gai_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .raw   (sample.raw_x),
    .angle (lane_angle_x),
    .busy  (lane_busy[0])
  );

  gai_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .raw   (sample.raw_y),
    .angle (lane_angle_y),
    .busy  (lane_busy[1])
  );

  gai_lane u_lane_z (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .raw   (sample.raw_z),
    .angle (lane_angle_z),
    .busy  (lane_busy[2])
  );

  assign lanes_busy = |lane_busy;
  assign res_load   = (state == S_RUN) && !lanes_busy && (!res_valid || result.ready);

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= SAMPLE_PERIOD_RESET;
      rate_gain     <= RATE_GAIN_RESET;
      cal_count     <= CAL_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SAMPLE_PERIOD: sample_period <= cfg.data[15:0];
        REG_RATE_GAIN:     rate_gain     <= cfg.data[23:0];
        REG_CAL_COUNT:     cal_count     <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Elapsed time and calibration sample count
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= ELAPSED_RESET;
      seen    <= '0;
    end else if (accept) begin
      if (sample.action) begin
        seen <= cal_complete ? 16'd0 : seen_inc;
      end else begin
        elapsed <= integ_now ? 20'd0 : elapsed_sat;
      end
    end
  end

  // Sequencer and merged result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (res_valid && result.ready) begin
            res_valid <= 1'b0;
          end
          if (accept) begin
            pend_updated <= cmd.integ;
            pend_done    <= cmd.cal && cal_complete;
            state        <= S_RUN;
          end
        end
        S_RUN: begin
          if (res_load) begin
            res_valid   <= 1'b1;
            res_angle_x <= lane_angle_x;
            res_angle_y <= lane_angle_y;
            res_angle_z <= lane_angle_z;
            res_updated <= pend_updated;
            res_done    <= pend_done;
            state       <= S_IDLE;
          end else if (res_valid && result.ready) begin
            res_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready            = (state == S_IDLE);
  assign result.valid            = res_valid;
  assign result.angle_x          = res_angle_x;
  assign result.angle_y          = res_angle_y;
  assign result.angle_z          = res_angle_z;
  assign result.angle_updated    = res_updated;
  assign result.calibration_done = res_done;

  assign res_in_range = (res_angle_x <= ANGLE_HALF) && (res_angle_x >= -ANGLE_HALF) &&
                        (res_angle_y <= ANGLE_HALF) && (res_angle_y >= -ANGLE_HALF) &&
                        (res_angle_z <= ANGLE_HALF) && (res_angle_z >= -ANGLE_HALF);

  `GAI_ASSERT_IMP(a_ready_lanes_idle, clk, rst, sample.ready, !lanes_busy)
  `GAI_ASSERT_NXT(a_transfer_blocks, clk, rst, accept, !sample.ready)
  `GAI_ASSERT_IMP(a_elapsed_sat, clk, rst, 1'b1, elapsed <= ELAPSED_MAX)
  `GAI_ASSERT_IMP(a_angle_range, clk, rst, res_valid, res_in_range)

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
  import gai_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_REV = 64'sd773094113280;
  localparam longint FULL_REV = 64'sd1546188226560;
  localparam logic [20:0] MAX_ELAPSED_US = 21'd1000000;

  typedef struct packed {
    logic               action;
    logic        [15:0] delta_us;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [40:0] angle_x;
    logic signed [40:0] angle_y;
    logic signed [40:0] angle_z;
    logic               angle_updated;
    logic               calibration_done;
  } angles_t;

  class angle_scoreboard;
    logic [15:0] period;
    logic [23:0] gain;
    logic [15:0] cal_total;
    logic [19:0] elapsed;
    longint      angle [3];
    int          bias [3];
    int          cal_sum [3];
    logic [15:0] cal_seen;
    angles_t     angles_q [$];
    int          fail_count;

    function new();
      period    = 16'd2000;
      gain      = 24'd2462907;
      cal_total = 16'd1000;
      elapsed   = 20'd10000;
      cal_seen  = 16'd0;
      fail_count = 0;
      for (int i = 0; i < 3; i++) begin
        angle[i]   = 0;
        bias[i]    = 0;
        cal_sum[i] = 0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] value);
      case (idx)
        REG_SAMPLE_PERIOD: period = value[15:0];
        REG_RATE_GAIN:     gain = value;
        REG_CAL_COUNT:     cal_total = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return angles_q.size();
    endfunction

    function void note_sample(sample_t s);
      logic signed [15:0] raw [3];
      logic        [16:0] divisor;
      logic        [20:0] sum_time;
      logic signed [127:0] prod;
      longint             quot;
      longint             diff;
      longint             acc;
      longint             turns;
      angles_t            r;
      int                 i;
      raw[0] = s.raw_x;
      raw[1] = s.raw_y;
      raw[2] = s.raw_z;
      r.angle_updated = 1'b0;
      r.calibration_done = 1'b0;
      if (s.action) begin
        // a zero count behaves as one
        divisor = (cal_total == 16'd0) ? 17'd1 : {1'b0, cal_total};
        for (i = 0; i < 3; i++) cal_sum[i] += raw[i];
        cal_seen = cal_seen + 16'd1;
        if ({1'b0, cal_seen} >= divisor) begin
          for (i = 0; i < 3; i++) begin
            quot = longint'(cal_sum[i]) * 65536 / longint'(divisor);
            if (quot > 64'sd2147483647) quot = 64'sd2147483647;
            else if (quot < -64'sd2147483648) quot = -64'sd2147483648;
            bias[i]    = int'(quot);
            cal_sum[i] = 0;
          end
          cal_seen = 16'd0;
          r.calibration_done = 1'b1;
        end
      end else begin
        sum_time = {1'b0, elapsed} + {5'd0, s.delta_us};
        if (sum_time > MAX_ELAPSED_US) sum_time = MAX_ELAPSED_US;
        elapsed = sum_time[19:0];
        if (elapsed >= {4'd0, period}) begin
          for (i = 0; i < 3; i++) begin
            diff = longint'(raw[i]) * 65536 - longint'(bias[i]);
            prod = diff;
            prod = prod * longint'(elapsed);
            prod = prod * longint'(gain);
            // floor of the product scaled down by 2^32
            acc = angle[i] + longint'(prod >>> 32);
            if (acc > HALF_REV) begin
              turns = (acc - HALF_REV + FULL_REV - 1) / FULL_REV;
              acc = acc - turns * FULL_REV;
            end else if (acc < -HALF_REV) begin
              turns = (-HALF_REV - acc + FULL_REV - 1) / FULL_REV;
              acc = acc + turns * FULL_REV;
            end
            angle[i] = acc;
          end
          elapsed = 20'd0;
          r.angle_updated = 1'b1;
        end
      end
      r.angle_x = angle[0][40:0];
      r.angle_y = angle[1][40:0];
      r.angle_z = angle[2][40:0];
      angles_q.push_back(r);
    endfunction

    function void report_mismatch(string field, logic [40:0] want, logic [40:0] got);
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_result(angles_t got);
      angles_t want;
      if (angles_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result transfer with no expected result: %h", got);
        return;
      end
      want = angles_q.pop_front();
      if (got.angle_x !== want.angle_x) report_mismatch("angle_x", want.angle_x, got.angle_x);
      if (got.angle_y !== want.angle_y) report_mismatch("angle_y", want.angle_y, got.angle_y);
      if (got.angle_z !== want.angle_z) report_mismatch("angle_z", want.angle_z, got.angle_z);
      if (got.angle_updated !== want.angle_updated)
        report_mismatch("angle_updated", 41'(want.angle_updated), 41'(got.angle_updated));
      if (got.calibration_done !== want.calibration_done)
        report_mismatch("calibration_done", 41'(want.calibration_done),
                        41'(got.calibration_done));
    endfunction
  endclass

  logic clk;
  logic rst;

  gai_sample_if sample_ch ();
  gai_result_if result_ch ();
  gai_cfg_if    cfg_ch ();

  gyro_angle_integrator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  angle_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;
  int cur_period = 2000;
  int cur_count = 1000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic sample_t make_item(logic action, logic [15:0] delta,
                                        logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_t s;
    s.action   = action;
    s.delta_us = delta;
    s.raw_x    = x;
    s.raw_y    = y;
    s.raw_z    = z;
    return s;
  endfunction

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4, 5: return 16'($urandom_range(0, 400) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_delta();
    int lim;
    lim = (cur_period < 32768) ? cur_period * 2 + 1 : 65535;
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.action   <= s.action;
    sample_ch.delta_us <= s.delta_us;
    sample_ch.raw_x    <= s.raw_x;
    sample_ch.raw_y    <= s.raw_y;
    sample_ch.raw_z    <= s.raw_z;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // drop valid and hold until every expected result has been taken
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_one(cfg_reg_t idx, logic [23:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic write_regs(logic [15:0] period, logic [23:0] gain, logic [15:0] count);
    write_one(REG_SAMPLE_PERIOD, 24'(period));
    write_one(REG_RATE_GAIN, gain);
    write_one(REG_CAL_COUNT, 24'(count));
    cfg_ch.valid <= 1'b0;
    cur_period = period;
    cur_count = count;
  endtask

  // result side: check each transfer, then decide ready for the next edge
  initial begin
    angles_t got;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got.angle_x          = result_ch.angle_x;
        got.angle_y          = result_ch.angle_y;
        got.angle_z          = result_ch.angle_z;
        got.angle_updated    = result_ch.angle_updated;
        got.calibration_done = result_ch.calibration_done;
        sb.check_result(got);
      end
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    int          phase;
    int          n;
    int          len;
    int          k;
    bit          paused;
    logic [15:0] base [3];
    rst                = 1'b1;
    sample_ch.valid    = 1'b0;
    sample_ch.action   = 1'b0;
    sample_ch.delta_us = 16'd0;
    sample_ch.raw_x    = 16'sd0;
    sample_ch.raw_y    = 16'sd0;
    sample_ch.raw_z    = 16'sd0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_SAMPLE_PERIOD;
    cfg_ch.data        = 24'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Six 30 degree steps land exactly on +180 and -180, the seventh wraps.
    write_regs(16'd32768, 24'h800000, 16'd1000);
    send_sample(make_item(1'b0, 16'd32768, 16'd0, 16'd0, 16'd0));
    repeat (6) send_sample(make_item(1'b0, 16'd32768, 16'd30720, -16'sd30720, 16'd0));
    send_sample(make_item(1'b0, 16'd32768, 16'd30720, -16'sd30720, 16'd0));
    send_sample(make_item(1'b0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF));
    send_sample(make_item(1'b0, 16'd0, 16'd1234, 16'd1234, 16'd1234));

    // zero period and zero count: every tick steps, every calibration sample completes
    drain_results();
    write_regs(16'd0, 24'hFFFFFF, 16'd0);
    send_sample(make_item(1'b0, 16'd0, 16'h7FFF, 16'h8000, 16'h5555));
    send_sample(make_item(1'b0, 16'd3, 16'h7FFF, 16'h8000, 16'h5555));
    send_sample(make_item(1'b1, 16'hFFFF, 16'd100, -16'sd200, 16'h7FFF));
    send_sample(make_item(1'b0, 16'd1, 16'h8000, 16'hAAAA, 16'd0));

    // lower the count in the middle of a calibration so the biases saturate
    drain_results();
    write_regs(16'd0, 24'hFFFFFF, 16'd4);
    repeat (3) send_sample(make_item(1'b1, 16'd0, 16'h7FFF, 16'h8000, 16'd1));
    drain_results();
    write_regs(16'd0, 24'hFFFFFF, 16'd1);
    send_sample(make_item(1'b1, 16'd77, 16'h7FFF, 16'h8000, 16'd1));
    send_sample(make_item(1'b0, 16'd5, 16'd0, 16'd0, 16'd0));

    drain_results();
    write_regs(16'hFFFF, 24'd0, 16'hFFFF);
    send_sample(make_item(1'b0, 16'hFFFF, 16'd9, 16'd9, 16'd9));
    send_sample(make_item(1'b0, 16'hFFFE, 16'd9, 16'd9, 16'd9));
    send_sample(make_item(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd9));
    send_sample(make_item(1'b1, 16'd0, 16'd3, 16'd3, 16'd3));

    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
        default: begin src_idle_pct = 19; snk_stall_pct = 19; end
      endcase
      case (phase)
        0: write_regs(16'd2000, 24'd2462907, 16'd4);
        1: write_regs(16'd0, 24'hFFFFFF, 16'd1);
        2: write_regs(16'($urandom_range(1, 5000)), 24'($urandom), 16'($urandom_range(2, 8)));
        3: write_regs(16'hFFFF, 24'($urandom), 16'd3);
        4: write_regs(16'($urandom_range(0, 300)), 24'($urandom_range(0, 4000000)), 16'd0);
        5: write_regs(16'($urandom), 24'($urandom), 16'($urandom_range(1, 12)));
        6: write_regs(16'd2000, 24'd1, 16'd40);
        default: write_regs(16'($urandom_range(500, 3000)), 24'hFFFFFF, 16'd6);
      endcase
      // long receiver hold-off while the sender keeps offering
      if (phase == 0) hold_cycles = 400;
      paused = 1'b0;
      n = 0;
      while (n < 250) begin
        if (phase == 4 && !paused && n >= 125) begin
          drain_results();
          paused = 1'b1;
        end
        k = $urandom_range(99);
        if (k < 15) begin
          len = (cur_count == 0) ? 1 : cur_count;
          if ($urandom_range(9) == 0) len = $urandom_range(1, len);
          for (int i = 0; i < 3; i++)
            base[i] = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 200) - 100);
          repeat (len) begin
            send_sample(make_item(1'b1, 16'($urandom),
                                  16'(base[0] + $urandom_range(0, 16) - 8),
                                  16'(base[1] + $urandom_range(0, 16) - 8),
                                  16'(base[2] + $urandom_range(0, 16) - 8)));
            n++;
          end
        end else if (k < 20) begin
          send_sample(make_item(1'b1, 16'($urandom), rand_raw(), rand_raw(), rand_raw()));
          n++;
        end else begin
          repeat ($urandom_range(1, 10)) begin
            send_sample(make_item(1'b0, rand_delta(), rand_raw(), rand_raw(), rand_raw()));
            n++;
          end
        end
      end
    end

    drain_results();
    repeat (80) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
